### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape / UTF-8 block.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_CLOSED    = 3'd1;
	localparam logic [2:0] ST_BAD_ESC   = 3'd2;
	localparam logic [2:0] ST_BAD_HEX   = 3'd3;
	localparam logic [2:0] ST_NO_LOW    = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_HEX1    = 3'd2,
		MODE_SURR_BS = 3'd3,
		MODE_SURR_U  = 3'd4,
		MODE_HEX2    = 3'd5
	} mode_t;

	// one decoded input byte: up to four output bytes and their status
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            has_bytes;
		logic [2:0]      status;
	} run_t;

endpackage

### src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one string byte per transfer and builds its run.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     in_byte,
	input  logic           end_of_input,
	output jsu_pkg::run_t  run
);

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_U      = 8'h75;

	jsu_pkg::mode_t mode_q, mode_d;
	logic [15:0]    acc_q, acc_d;
	logic [1:0]     cnt_q, cnt_d;
	logic [9:0]     hs_q, hs_d;
	logic           drop_q, drop_d;

	logic [2:0]     err;
	logic           hex_ok;
	logic [3:0]     hex_d;
	logic [15:0]    acc_n;
	logic [20:0]    code4;

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_d = in_byte[3:0];
		end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
		             (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
			hex_d = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_n = {acc_q[11:0], hex_d};
	assign code4 = {1'b0, hs_q, acc_n[9:0]} + 21'h10000;

	always_comb begin
		mode_d        = mode_q;
		acc_d         = acc_q;
		cnt_d         = cnt_q;
		hs_d          = hs_q;
		drop_d        = drop_q;
		err           = jsu_pkg::ST_OK;
		run.bytes     = '0;
		run.last_idx  = 2'd0;
		run.has_bytes = 1'b0;
		run.status    = jsu_pkg::ST_OK;

		if (drop_q) begin
			if (in_byte == CH_QUOTE) begin
				run.status = jsu_pkg::ST_CLOSED;
				drop_d     = 1'b0;
			end
		end else begin
			case (mode_q)
				jsu_pkg::MODE_ESC: begin
					mode_d        = jsu_pkg::MODE_NORMAL;
					run.has_bytes = 1'b1;
					case (in_byte)
						CH_N:      run.bytes[0] = 8'h0A;
						CH_R:      run.bytes[0] = 8'h0D;
						CH_T:      run.bytes[0] = 8'h09;
						CH_F:      run.bytes[0] = 8'h0C;
						CH_B:      run.bytes[0] = 8'h08;
						CH_QUOTE:  run.bytes[0] = CH_QUOTE;
						CH_SLASH:  run.bytes[0] = CH_SLASH;
						CH_BSLASH: run.bytes[0] = CH_BSLASH;
						CH_U: begin
							run.has_bytes = 1'b0;
							mode_d        = jsu_pkg::MODE_HEX1;
							acc_d         = '0;
							cnt_d         = '0;
						end
						default: begin
							run.has_bytes = 1'b0;
							err           = jsu_pkg::ST_BAD_ESC;
						end
					endcase
				end
				jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
					if (!hex_ok) begin
						err = jsu_pkg::ST_BAD_HEX;
					end else if (cnt_q != 2'd3) begin
						acc_d = acc_n;
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d  = '0;
						acc_d  = '0;
						mode_d = jsu_pkg::MODE_NORMAL;
						if (mode_q == jsu_pkg::MODE_HEX1) begin
							if (acc_n >= 16'hD800 && acc_n <= 16'hDFFF) begin
								hs_d   = acc_n[9:0];
								mode_d = jsu_pkg::MODE_SURR_BS;
							end else if (acc_n <= 16'h007F) begin
								run.has_bytes = 1'b1;
								run.bytes[0]  = acc_n[7:0];
							end else if (acc_n <= 16'h07FF) begin
								run.has_bytes = 1'b1;
								run.last_idx  = 2'd1;
								run.bytes[0]  = {3'b110, acc_n[10:6]};
								run.bytes[1]  = {2'b10, acc_n[5:0]};
							end else begin
								run.has_bytes = 1'b1;
								run.last_idx  = 2'd2;
								run.bytes[0]  = {4'b1110, acc_n[15:12]};
								run.bytes[1]  = {2'b10, acc_n[11:6]};
								run.bytes[2]  = {2'b10, acc_n[5:0]};
							end
						end else begin
							hs_d          = '0;
							run.has_bytes = 1'b1;
							run.last_idx  = 2'd3;
							run.bytes[0]  = {5'b11110, code4[20:18]};
							run.bytes[1]  = {2'b10, code4[17:12]};
							run.bytes[2]  = {2'b10, code4[11:6]};
							run.bytes[3]  = {2'b10, code4[5:0]};
						end
					end
				end
				jsu_pkg::MODE_SURR_BS: begin
					if (in_byte == CH_BSLASH) mode_d = jsu_pkg::MODE_SURR_U;
					else err = jsu_pkg::ST_NO_LOW;
				end
				jsu_pkg::MODE_SURR_U: begin
					if (in_byte == CH_U) begin
						mode_d = jsu_pkg::MODE_HEX2;
						acc_d  = '0;
						cnt_d  = '0;
					end else begin
						err = jsu_pkg::ST_NO_LOW;
					end
				end
				default: begin
					if (in_byte == CH_QUOTE) begin
						run.status = jsu_pkg::ST_CLOSED;
						mode_d     = jsu_pkg::MODE_NORMAL;
						acc_d      = '0;
						cnt_d      = '0;
						hs_d       = '0;
					end else if (in_byte == CH_BSLASH) begin
						mode_d = jsu_pkg::MODE_ESC;
					end else begin
						run.has_bytes = 1'b1;
						run.bytes[0]  = in_byte;
					end
				end
			endcase

			if (err != jsu_pkg::ST_OK) begin
				run.status    = err;
				run.has_bytes = 1'b0;
				run.bytes     = '0;
				run.last_idx  = 2'd0;
				mode_d        = jsu_pkg::MODE_NORMAL;
				acc_d         = '0;
				cnt_d         = '0;
				hs_d          = '0;
				drop_d        = (in_byte != CH_QUOTE);
			end
		end

		if (end_of_input) begin
			if (run.status == jsu_pkg::ST_OK && !drop_d && mode_d != jsu_pkg::MODE_NORMAL)
				run.status = jsu_pkg::ST_TRUNCATED;
			mode_d = jsu_pkg::MODE_NORMAL;
			acc_d  = '0;
			cnt_d  = '0;
			hs_d   = '0;
			drop_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_NORMAL;
			acc_q  <= '0;
			cnt_q  <= '0;
			hs_q   <= '0;
			drop_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			hs_q   <= hs_d;
			drop_q <= drop_d;
		end
	end

endmodule

### src/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of decoded runs between the decoder and the output serializer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsu_pkg::run_t  wr_data,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output jsu_pkg::run_t  rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	jsu_pkg::run_t      mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: issues the bytes of each queued run, one per transfer.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nonempty,
	input  jsu_pkg::run_t  head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic [3:0]     m_tuser,
	output logic           m_tlast
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load    = nonempty && (!m_tvalid || m_tready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load)          m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (pop)           idx_q <= '0;
			else if (load)     idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= head.has_bytes ? head.bytes[idx_q] : 8'h00;
			m_tuser <= {head.status, head.has_bytes};
			m_tlast <= at_last;
		end
	end

endmodule

### src/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string body decoder: escapes and \u code units to UTF-8.
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tuser                 | tlast
//  s_*     | in  | in_byte        | -                     | end_of_input
//  m_*     | out | out_byte       | byte_valid, status    | last_of_run
//
//  One input byte per cycle while the run queue has room; each byte becomes
//  a run of 1 to 4 output transfers, drained at one per cycle while m_tready
//  is high by the serializer, so output-heavy runs set the sustained rate.
//  Reset clears decoder state, queue pointers and output valid; no sweep.
//  Either side may stall on its own; the queue absorbs the difference.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [3:0] m_tuser,   // [0] byte_valid, [3:1] status
	output logic       m_tlast
);

	jsu_pkg::run_t run, head;
	logic          take, full, nonempty, pop;

	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.in_byte      (s_tdata),
		.end_of_input (s_tlast),
		.run          (run)
	);

	jsu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.wr_data  (run),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rd_data  (head)
	);

	jsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### src/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks of the output stream of json_string_unescape_utf8.
// ----------------------------------------------------------------------------
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [3:0] m_tuser,
	input logic       m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("output transfer changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00 && m_tlast)
		else $error("byteless result not a single zero transfer");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[3:1] == jsu_pkg::ST_OK)
		else $error("decoded byte carries nonzero status");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[3:1] <= jsu_pkg::ST_TRUNCATED)
		else $error("status code out of range");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
